### hw/rtl/diff_drive_odometry_macros.svh
// assertion macros shared by the odometry rtl
// expects clk and rst_n in the scope of the module that uses them
`ifndef DIFF_DRIVE_ODOMETRY_MACROS_SVH
`define DIFF_DRIVE_ODOMETRY_MACROS_SVH
`ifndef SYNTH
`define ODO_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("odometry check failed");
`define ODO_ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) pre |=> post) \
        else $error("odometry sequence check failed");
`else
`define ODO_ASSERT(lbl, prop)
`define ODO_ASSERT_NEXT(lbl, pre, post)
`endif
`endif

### hw/rtl/odo_pkg.sv
// shared constants, types and helper functions for the odometry block
// no dependencies
`timescale 1ns / 1ps
package odo_pkg;

    localparam int FRAC_BITS    = 16;
    localparam int CORDIC_STEPS = 16;
    localparam int CORDIC_CNT_W = $clog2(CORDIC_STEPS + 1);
    localparam int Q30          = 30;

    localparam int ANG_W   = 19;
    localparam int CS_W    = 32;
    localparam int CFG_W   = 20;
    localparam int IN_W    = 88;
    localparam int OUT_W   = 184;

    localparam int MUL_A_W   = 44;
    localparam int MUL_B_W   = 32;
    localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
    localparam int MUL_CNT_W = $clog2(MUL_B_W + 1);

    localparam int DIV_N_W   = 64;
    localparam int DIV_D_W   = 24;
    localparam int DIV_CNT_W = $clog2(DIV_N_W);

    localparam logic [63:0] PI_Q60 = 64'd3622009729038561421;
    localparam logic [63:0] PI_W = (PI_Q60 + (64'd1 << (59 - FRAC_BITS))) >> (60 - FRAC_BITS);
    localparam logic [63:0] TWO_PI_W =
        (PI_Q60 + (64'd1 << (58 - FRAC_BITS))) >> (59 - FRAC_BITS);
    localparam logic [63:0] HALF_PI_W =
        (PI_Q60 + (64'd1 << (60 - FRAC_BITS))) >> (61 - FRAC_BITS);

    localparam logic signed [ANG_W:0] PI_Q      = (ANG_W + 1)'(PI_W);
    localparam logic signed [ANG_W:0] TWO_PI_Q  = (ANG_W + 1)'(TWO_PI_W);
    localparam logic signed [ANG_W:0] HALF_PI_Q = (ANG_W + 1)'(HALF_PI_W);

    localparam logic [31:0] GAIN_Q30   = 32'd652032874;
    localparam logic [31:0] RATE_SCALE = 32'd1000000;

    localparam logic [CFG_W-1:0] RADIUS_RST = CFG_W'(((64'd16 << FRAC_BITS) + 64'd50) / 64'd100);
    localparam logic [CFG_W-1:0] BASE_RST   = CFG_W'(64'd1 << (FRAC_BITS - 1));

    localparam logic [31:0] ATAN_TAB [11] = '{
        32'd843314857, 32'd497837829, 32'd263043837, 32'd133525159, 32'd67021687,
        32'd33543516,  32'd16775851,  32'd8388437,   32'd4194283,   32'd2097149,
        32'd1048576
    };

    typedef struct packed {
        logic busy;
        logic done;
    } unit_stat_t;

    // arctangent of 2^-i in q30
    function automatic logic [31:0] atan_step(input logic [5:0] i);
        logic [31:0] r;
        if (i < 6'd11)
            r = ATAN_TAB[i[3:0]];
        else if (i <= 6'd30)
            r = 32'd1 << (6'd30 - i);
        else
            r = '0;
        return r;
    endfunction

endpackage

### hw/rtl/odo_mul.sv
// serial shift-add multiplier, one multiplier bit per cycle, sign applied at the end
// depends on odo_pkg
`timescale 1ns / 1ps
module odo_mul
    import odo_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic signed [MUL_A_W-1:0] a,
    input  logic signed [MUL_B_W-1:0] b,
    output logic signed [MUL_P_W-1:0] prod,
    output unit_stat_t                stat
);

    logic [MUL_A_W-1:0]        a_mag;
    logic [MUL_B_W-1:0]        b_mag;
    logic [MUL_P_W-1:0]        acc_reg;
    logic [MUL_P_W-1:0]        mcand_reg;
    logic [MUL_B_W-1:0]        mplier_reg;
    logic [MUL_CNT_W-1:0]      cnt_reg;
    logic                      neg_reg;
    logic                      busy_reg;
    logic                      done_reg;
    logic signed [MUL_P_W-1:0] prod_reg;

    always_comb
    begin
        a_mag = a[MUL_A_W-1] ? MUL_A_W'(-a) : MUL_A_W'(a);
        b_mag = b[MUL_B_W-1] ? MUL_B_W'(-b) : MUL_B_W'(b);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg    <= '0;
            mcand_reg  <= '0;
            mplier_reg <= '0;
            cnt_reg    <= '0;
            neg_reg    <= 1'b0;
            busy_reg   <= 1'b0;
            done_reg   <= 1'b0;
            prod_reg   <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg   <= 1'b1;
                cnt_reg    <= '0;
                acc_reg    <= '0;
                mcand_reg  <= MUL_P_W'(a_mag);
                mplier_reg <= b_mag;
                neg_reg    <= a[MUL_A_W-1] ^ b[MUL_B_W-1];
            end
            else if (busy_reg)
            begin
                if (cnt_reg == MUL_CNT_W'(MUL_B_W))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                    prod_reg <= neg_reg ? -$signed(acc_reg) : $signed(acc_reg);
                end
                else
                begin
                    if (mplier_reg[0])
                        acc_reg <= acc_reg + mcand_reg;
                    mcand_reg  <= mcand_reg << 1;
                    mplier_reg <= mplier_reg >> 1;
                    cnt_reg    <= cnt_reg + 1'b1;
                end
            end
        end
    end

    assign prod      = prod_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

### hw/rtl/odo_div.sv
// serial restoring divider, one quotient bit per cycle
// depends on odo_pkg
`timescale 1ns / 1ps
module odo_div
    import odo_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [DIV_N_W-1:0] num,
    input  logic [DIV_D_W-1:0] den,
    output logic [DIV_N_W-1:0] quot,
    output logic [DIV_D_W-1:0] rem,
    output unit_stat_t         stat
);

    logic [DIV_N_W-1:0]   quo_reg;
    logic [DIV_D_W:0]     rem_reg;
    logic [DIV_D_W-1:0]   den_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_D_W:0]     shifted;
    logic [DIV_D_W+1:0]   trial;
    logic                 fits;

    always_comb
    begin
        shifted = {rem_reg[DIV_D_W-1:0], quo_reg[DIV_N_W-1]};
        trial   = {1'b0, shifted} - {2'b00, den_reg};
        fits    = !trial[DIV_D_W+1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quo_reg  <= '0;
            rem_reg  <= '0;
            den_reg  <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                quo_reg  <= num;
                rem_reg  <= '0;
                den_reg  <= den;
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                rem_reg <= fits ? trial[DIV_D_W:0] : shifted;
                quo_reg <= {quo_reg[DIV_N_W-2:0], fits};
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(DIV_N_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign quot      = quo_reg;
    assign rem       = rem_reg[DIV_D_W-1:0];
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

### hw/rtl/odo_cordic.sv
// iterative rotation-mode cordic giving q30 cosine and sine, one step per cycle
// depends on odo_pkg
`timescale 1ns / 1ps
module odo_cordic
    import odo_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic signed [ANG_W-1:0] ang,
    output logic signed [CS_W-1:0]  cos_q,
    output logic signed [CS_W-1:0]  sin_q,
    output unit_stat_t              stat
);

    localparam int CW = CS_W + 2;

    logic signed [CW-1:0]     x_reg;
    logic signed [CW-1:0]     y_reg;
    logic signed [CW-1:0]     z_reg;
    logic [CORDIC_CNT_W-1:0]  cnt_reg;
    logic                     neg_reg;
    logic                     busy_reg;
    logic                     done_reg;
    logic signed [CS_W-1:0]   cos_reg;
    logic signed [CS_W-1:0]   sin_reg;

    logic signed [ANG_W:0]    ang_ext;
    logic signed [ANG_W:0]    folded;
    logic                     fold;
    logic signed [CW-1:0]     x_sh;
    logic signed [CW-1:0]     y_sh;
    logic signed [CW-1:0]     at;

    always_comb
    begin
        ang_ext = (ANG_W + 1)'(ang);
        fold    = 1'b1;
        if (ang_ext > HALF_PI_Q)
            folded = ang_ext - PI_Q;
        else if (ang_ext < -HALF_PI_Q)
            folded = ang_ext + PI_Q;
        else
        begin
            folded = ang_ext;
            fold   = 1'b0;
        end
        x_sh = x_reg >>> cnt_reg;
        y_sh = y_reg >>> cnt_reg;
        at   = CW'(atan_step(6'(cnt_reg)));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_reg    <= '0;
            y_reg    <= '0;
            z_reg    <= '0;
            cnt_reg  <= '0;
            neg_reg  <= 1'b0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cos_reg  <= '0;
            sin_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                x_reg    <= CW'(GAIN_Q30);
                y_reg    <= '0;
                z_reg    <= CW'(folded) <<< (Q30 - FRAC_BITS);
                neg_reg  <= fold;
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                if (cnt_reg == CORDIC_CNT_W'(CORDIC_STEPS))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                    cos_reg  <= neg_reg ? CS_W'(-x_reg) : CS_W'(x_reg);
                    sin_reg  <= neg_reg ? CS_W'(-y_reg) : CS_W'(y_reg);
                end
                else
                begin
                    if (!z_reg[CW-1])
                    begin
                        x_reg <= x_reg - y_sh;
                        y_reg <= y_reg + x_sh;
                        z_reg <= z_reg - at;
                    end
                    else
                    begin
                        x_reg <= x_reg + y_sh;
                        y_reg <= y_reg - x_sh;
                        z_reg <= z_reg + at;
                    end
                    cnt_reg <= cnt_reg + 1'b1;
                end
            end
        end
    end

    assign cos_q     = cos_reg;
    assign sin_q     = sin_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

### hw/rtl/diff_drive_odometry.sv
// Differential-drive wheel odometry. Each input transaction carries both absolute wheel
// angles and the elapsed microseconds; one output transaction returns pose, velocity
// components and turn rate in Q16.16 (the heading is 19 bits wide, with 16 fraction bits).
// One tick is handled at a time. A rate that is forced (elapsed_us zero, or a saturating
// value) skips the rate multiply and divide. The time is set by the bit-serial
// multiplier (up to nine products), the bit-serial divider (up to six quotients)
// and the cordic (run twice). A finished result waits in the output register while the
// next tick is taken. If that register is still full when the next result is ready, the
// block waits for it to drain.
// wr_en writes the wheel radius (index 0) or the wheel separation (index 1) and must only
// be used while the block is idle.
// depends on odo_pkg, odo_mul, odo_div, odo_cordic and the macro header
`timescale 1ns / 1ps
`include "diff_drive_odometry_macros.svh"
module diff_drive_odometry
    import odo_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    // left_wheel_angle[31:0], right_wheel_angle[63:32], elapsed_us[87:64]
    input  logic [IN_W-1:0]  s_tdata,
    output logic             m_tvalid,
    input  logic             m_tready,
    // pos_x[31:0], pos_y[63:32], heading[82:64], vel_x[114:83], vel_y[146:115],
    // turn_rate[178:147], zero fill[183:179]
    output logic [OUT_W-1:0] m_tdata,
    input  logic             wr_en,
    input  logic             wr_index,
    input  logic [CFG_W-1:0] wr_data
);

    localparam logic REG_RADIUS = 1'b0;
    localparam logic REG_BASE   = 1'b1;
    localparam int   WR_W = ANG_W + 2;

    typedef enum logic [4:0] {
        S_IDLE, S_DIST, S_DIFF, S_TURN, S_MID, S_CMID, S_POSX, S_POSY,
        S_HEAD, S_CHEAD, S_PX, S_PY, S_RCHK, S_RMUL, S_RDIV, S_DONE
    } state_t;

    typedef enum logic [1:0] {RS_VX, RS_VY, RS_TR} rsel_t;

    state_t                    state_reg;
    rsel_t                     sel_reg;
    logic                      go_reg;
    logic [CFG_W-1:0]          rad_reg;
    logic [CFG_W-1:0]          base_reg;
    logic signed [31:0]        prev_l_reg;
    logic signed [31:0]        prev_r_reg;
    logic signed [31:0]        x_reg;
    logic signed [31:0]        y_reg;
    logic signed [ANG_W-1:0]   head_reg;
    logic signed [ANG_W-1:0]   mid_reg;
    logic signed [33:0]        sum_reg;
    logic signed [33:0]        diff_reg;
    logic [DIV_D_W-1:0]        dt_reg;
    logic signed [37:0]        dist_reg;
    logic signed [54:0]        turn_reg;
    logic signed [CS_W-1:0]    c_reg;
    logic signed [CS_W-1:0]    s_reg;
    logic signed [54:0]        rv_reg;
    logic signed [63:0]        rp_reg;
    logic signed [31:0]        vx_reg;
    logic signed [31:0]        vy_reg;
    logic signed [31:0]        tr_reg;
    logic                      m_tvalid_reg;
    logic [OUT_W-1:0]          m_tdata_reg;

    logic signed [31:0]        in_left;
    logic signed [31:0]        in_right;
    logic signed [32:0]        dl;
    logic signed [32:0]        dr;
    logic signed [55:0]        v_mid;
    logic signed [55:0]        v_head;
    logic signed [45:0]        prod_q30;
    logic signed [46:0]        x_sum;
    logic signed [46:0]        y_sum;

    logic                      mul_owner;
    logic                      mul_start;
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [MUL_P_W-1:0] mul_prod;
    unit_stat_t                mul_stat;

    logic                      div_start;
    logic signed [63:0]        div_sv;
    logic                      div_neg;
    logic [DIV_N_W-1:0]        div_num;
    logic [DIV_D_W-1:0]        div_den;
    logic [DIV_N_W-1:0]        div_quot;
    logic [DIV_D_W-1:0]        div_rem;
    unit_stat_t                div_stat;

    logic                      cor_start;
    logic signed [ANG_W-1:0]   cor_ang;
    logic signed [CS_W-1:0]    cor_cos;
    logic signed [CS_W-1:0]    cor_sin;
    unit_stat_t                cor_stat;

    logic                      rate_skip;
    logic                      rate_wr;
    logic signed [31:0]        rate_val;
    logic signed [31:0]        rate_div;

    // remainder of a magnitude division back to a signed angle in [-pi, pi]
    function automatic logic signed [ANG_W-1:0] wrap_fix(input logic [DIV_D_W-1:0] r,
                                                         input logic neg);
        logic signed [WR_W-1:0] v;
        v = $signed({2'b00, r[ANG_W-1:0]});
        if (neg)
            v = -v;
        if (v < 0)
            v = v + TWO_PI_Q;
        if (v > PI_Q)
            v = v - TWO_PI_Q;
        return v[ANG_W-1:0];
    endfunction

    function automatic logic signed [31:0] sat_pos(input logic signed [46:0] v);
        logic signed [31:0] r;
        if (v > 47'sd2147483647)
            r = 32'sh7fffffff;
        else if (v < -47'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

    function automatic logic signed [31:0] sat_rate(input logic [DIV_N_W-1:0] q,
                                                    input logic neg);
        logic signed [31:0] r;
        if (!neg)
            r = (q > 64'd2147483647) ? 32'sh7fffffff : $signed(q[31:0]);
        else
            r = (q > 64'd2147483648) ? 32'sh80000000 : -$signed(q[31:0]);
        return r;
    endfunction

    always_comb
    begin
        in_left  = s_tdata[31:0];
        in_right = s_tdata[63:32];
        dl       = 33'(in_left) - 33'(prev_l_reg);
        dr       = 33'(in_right) - 33'(prev_r_reg);
        v_mid    = 56'(turn_reg >>> 1) + 56'(head_reg);
        v_head   = 56'(turn_reg) + 56'(head_reg);
        prod_q30 = $signed(mul_prod[MUL_P_W-1:Q30]);
        x_sum    = 47'(x_reg) + 47'(prod_q30);
        y_sum    = 47'(y_reg) + 47'(prod_q30);
    end

    // operand selection for the shared serial units
    always_comb
    begin
        mul_a = MUL_A_W'(dist_reg);
        mul_b = c_reg;
        unique case (state_reg)
            S_DIST:
            begin
                mul_a = MUL_A_W'(sum_reg);
                mul_b = MUL_B_W'(rad_reg);
            end
            S_DIFF:
            begin
                mul_a = MUL_A_W'(diff_reg);
                mul_b = MUL_B_W'(rad_reg);
            end
            S_POSY, S_PY:
                mul_b = s_reg;
            S_RMUL:
            begin
                mul_a = rv_reg[MUL_A_W-1:0];
                mul_b = RATE_SCALE;
            end
            default:
                mul_b = c_reg;
        endcase

        unique case (state_reg)
            S_TURN:  div_sv = 64'(turn_reg);
            S_MID:   div_sv = 64'(v_mid);
            S_HEAD:  div_sv = 64'(v_head);
            default: div_sv = rp_reg;
        endcase
        div_neg = div_sv[63];
        div_num = div_neg ? DIV_N_W'(-div_sv) : DIV_N_W'(div_sv);

        unique case (state_reg)
            S_TURN:  div_den = (base_reg == '0) ? DIV_D_W'(1) : DIV_D_W'(base_reg);
            S_RDIV:  div_den = dt_reg;
            default: div_den = DIV_D_W'(TWO_PI_Q);
        endcase

        cor_ang   = (state_reg == S_CMID) ? mid_reg : head_reg;
        mul_owner = (state_reg == S_DIST || state_reg == S_DIFF ||
                     state_reg == S_POSX || state_reg == S_POSY || state_reg == S_PX ||
                     state_reg == S_PY || state_reg == S_RMUL);
        mul_start = go_reg && mul_owner;
        div_start = go_reg && (state_reg == S_TURN || state_reg == S_MID ||
                    state_reg == S_HEAD || state_reg == S_RDIV);
        cor_start = go_reg && (state_reg == S_CMID || state_reg == S_CHEAD);
    end

    // rate results: zero elapsed time and out-of-range values bypass the units
    always_comb
    begin
        rate_skip = 1'b1;
        if (dt_reg == '0)
            rate_val = '0;
        else if (rv_reg >= 55'sd8796093022208)
            rate_val = 32'sh7fffffff;
        else if (rv_reg <= -55'sd8796093022208)
            rate_val = 32'sh80000000;
        else
        begin
            rate_val  = '0;
            rate_skip = 1'b0;
        end
        rate_div = sat_rate(div_quot, div_neg);
        rate_wr  = (state_reg == S_RCHK && rate_skip) ||
                   (state_reg == S_RDIV && div_stat.done);
        if (state_reg == S_RDIV)
            rate_val = rate_div;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rad_reg  <= RADIUS_RST;
            base_reg <= BASE_RST;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                REG_RADIUS: rad_reg  <= wr_data;
                REG_BASE:   base_reg <= wr_data;
                default:    base_reg <= base_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            sel_reg      <= RS_VX;
            go_reg       <= 1'b0;
            prev_l_reg   <= '0;
            prev_r_reg   <= '0;
            x_reg        <= '0;
            y_reg        <= '0;
            head_reg     <= '0;
            mid_reg      <= '0;
            sum_reg      <= '0;
            diff_reg     <= '0;
            dt_reg       <= '0;
            dist_reg     <= '0;
            turn_reg     <= '0;
            c_reg        <= '0;
            s_reg        <= '0;
            rv_reg       <= '0;
            rp_reg       <= '0;
            vx_reg       <= '0;
            vy_reg       <= '0;
            tr_reg       <= '0;
            m_tvalid_reg <= 1'b0;
            m_tdata_reg  <= '0;
        end
        else
        begin
            go_reg <= 1'b0;
            if (m_tvalid_reg && m_tready)
                m_tvalid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                    if (s_tvalid)
                    begin
                        prev_l_reg <= in_left;
                        prev_r_reg <= in_right;
                        sum_reg    <= 34'(dl) + 34'(dr);
                        diff_reg   <= 34'(dr) - 34'(dl);
                        dt_reg     <= s_tdata[87:64];
                        state_reg  <= S_DIST;
                        go_reg     <= 1'b1;
                    end
                S_DIST:
                    if (mul_stat.done)
                    begin
                        dist_reg  <= 38'(mul_prod >>> (FRAC_BITS + 1));
                        state_reg <= S_DIFF;
                        go_reg    <= 1'b1;
                    end
                S_DIFF:
                    if (mul_stat.done)
                    begin
                        turn_reg  <= 55'(mul_prod);
                        state_reg <= S_TURN;
                        go_reg    <= 1'b1;
                    end
                S_TURN:
                    if (div_stat.done)
                    begin
                        turn_reg  <= div_neg ? -$signed(55'(div_quot)) : $signed(55'(div_quot));
                        state_reg <= S_MID;
                        go_reg    <= 1'b1;
                    end
                S_MID:
                    if (div_stat.done)
                    begin
                        mid_reg   <= wrap_fix(div_rem, div_neg);
                        state_reg <= S_CMID;
                        go_reg    <= 1'b1;
                    end
                S_CMID:
                    if (cor_stat.done)
                    begin
                        c_reg     <= cor_cos;
                        s_reg     <= cor_sin;
                        state_reg <= S_POSX;
                        go_reg    <= 1'b1;
                    end
                S_POSX:
                    if (mul_stat.done)
                    begin
                        x_reg     <= sat_pos(x_sum);
                        state_reg <= S_POSY;
                        go_reg    <= 1'b1;
                    end
                S_POSY:
                    if (mul_stat.done)
                    begin
                        y_reg     <= sat_pos(y_sum);
                        state_reg <= S_HEAD;
                        go_reg    <= 1'b1;
                    end
                S_HEAD:
                    if (div_stat.done)
                    begin
                        head_reg  <= wrap_fix(div_rem, div_neg);
                        state_reg <= S_CHEAD;
                        go_reg    <= 1'b1;
                    end
                S_CHEAD:
                    if (cor_stat.done)
                    begin
                        c_reg     <= cor_cos;
                        s_reg     <= cor_sin;
                        sel_reg   <= RS_VX;
                        state_reg <= S_PX;
                        go_reg    <= 1'b1;
                    end
                S_PX, S_PY:
                    if (mul_stat.done)
                    begin
                        rv_reg    <= 55'(prod_q30);
                        state_reg <= S_RCHK;
                    end
                S_RCHK:
                    if (!rate_skip)
                    begin
                        state_reg <= S_RMUL;
                        go_reg    <= 1'b1;
                    end
                S_RMUL:
                    if (mul_stat.done)
                    begin
                        rp_reg    <= mul_prod[63:0];
                        state_reg <= S_RDIV;
                        go_reg    <= 1'b1;
                    end
                S_RDIV:
                    state_reg <= S_RDIV;
                S_DONE:
                    if (!m_tvalid_reg || m_tready)
                    begin
                        m_tdata_reg  <= {5'd0, tr_reg, vy_reg, vx_reg, head_reg, y_reg, x_reg};
                        m_tvalid_reg <= 1'b1;
                        state_reg    <= S_IDLE;
                    end
                default:
                    state_reg <= S_IDLE;
            endcase

            if (rate_wr)
            begin
                unique case (sel_reg)
                    RS_VX:
                    begin
                        vx_reg    <= rate_val;
                        sel_reg   <= RS_VY;
                        state_reg <= S_PY;
                        go_reg    <= 1'b1;
                    end
                    RS_VY:
                    begin
                        vy_reg    <= rate_val;
                        sel_reg   <= RS_TR;
                        rv_reg    <= turn_reg;
                        state_reg <= S_RCHK;
                    end
                    default:
                    begin
                        tr_reg    <= rate_val;
                        state_reg <= S_DONE;
                    end
                endcase
            end
        end
    end

    odo_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .prod  (mul_prod),
        .stat  (mul_stat)
    );

    odo_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .quot  (div_quot),
        .rem   (div_rem),
        .stat  (div_stat)
    );

    odo_cordic u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cor_start),
        .ang   (cor_ang),
        .cos_q (cor_cos),
        .sin_q (cor_sin),
        .stat  (cor_stat)
    );

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    `ODO_ASSERT(a_one_unit_busy, $onehot0({mul_stat.busy, div_stat.busy, cor_stat.busy}))
    `ODO_ASSERT(a_heading_wrapped, (head_reg <= PI_Q) && (head_reg >= -PI_Q))
    `ODO_ASSERT(a_mul_done_owned, mul_stat.done |-> mul_owner)
    `ODO_ASSERT_NEXT(a_accept_starts, s_tvalid && s_tready, (state_reg == S_DIST) && go_reg)

endmodule
